// File: hw/rtl/ccsm_pkg.sv
// ----------------------------------------------------------------------------
// ccsm_pkg
// Shared types, codes and constants of the character-class sequence matcher.
// ----------------------------------------------------------------------------
package ccsm_pkg;

	// Default sizes and fixed field widths.
	localparam int MAX_CLASSES_DEF  = 32;
	localparam int MAX_CONSUMED_DEF = 4095;
	localparam int ALPHABET_SIZE    = 256;
	localparam int WORD_BITS        = 64;
	localparam int WORDS_PER_CLASS  = ALPHABET_SIZE / WORD_BITS;
	localparam int WORD_SEL_W       = 2;
	localparam int CHAR_W           = 8;
	localparam int CLS_IDX_W        = 5;
	localparam int PLEN_CFG_W       = 6;
	localparam int CONSUMED_W       = 12;

	// Item operation codes.
	typedef logic [1:0] op_t;
	localparam op_t OP_LOAD_MASK = 2'd0;
	localparam op_t OP_LOAD_OPER = 2'd1;
	localparam op_t OP_CHAR      = 2'd2;
	localparam op_t OP_END       = 2'd3;

	// Class operator codes.
	typedef logic [1:0] cls_op_t;
	localparam cls_op_t OPR_ONCE = 2'd0;
	localparam cls_op_t OPR_STAR = 2'd1;
	localparam cls_op_t OPR_PLUS = 2'd2;
	localparam cls_op_t OPR_OPT  = 2'd3;

	// Input item payload.
	typedef struct packed {
		op_t                   op;
		logic [CLS_IDX_W-1:0]  class_index;
		logic [WORD_SEL_W-1:0] mask_word_index;
		logic [WORD_BITS-1:0]  mask_word;
		cls_op_t               class_operator;
		logic [CHAR_W-1:0]     subject_char;
	} item_t;

	// Result item payload.
	typedef struct packed {
		logic                  matched;
		logic [CONSUMED_W-1:0] consumed;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_mask;
		logic load_oper;
		logic start;
		logic reread;
		logic apply;
		logic clear;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic decided;
		logic emit;
		logic more;
		logic out_free;
	} status_t;

endpackage

// File: hw/rtl/char_class_sequence_matcher_unit.sv
// ----------------------------------------------------------------------------
// char_class_sequence_matcher_unit
// Greedy character-class sequence matcher without backtracking.
// ----------------------------------------------------------------------------
// Loads of a mask word or a class operator leave the controller idle. A
// subject character is handled class by class: for every class it visits,
// the class's mask word and operator are read from the registered pattern
// memories, then evaluated. Each class passed over without consuming the
// character adds another read and evaluation. An end of subject takes one
// read and evaluation, or none when the subject is already decided, and a
// character of a decided subject is dropped. A result that finds the output
// register still occupied waits there until the consumer drains it. The
// pattern length register may be written only while no item is in flight,
// and a write starts a new subject.
module char_class_sequence_matcher_unit #(
	parameter int MAX_CLASSES  = ccsm_pkg::MAX_CLASSES_DEF,
	parameter int MAX_CONSUMED = ccsm_pkg::MAX_CONSUMED_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  ccsm_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output ccsm_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ccsm_pkg::PLEN_CFG_W-1:0] cfg_data
);

	ccsm_pkg::cmd_t    cmd;
	ccsm_pkg::status_t status;

	// The configuration register is always writable.
	assign cfg_ready = 1'b1;

	// Controller.
	ccsm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.op),
		.status     (status),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	// Datapath.
	ccsm_datapath #(
		.MAX_CLASSES  (MAX_CLASSES),
		.MAX_CONSUMED (MAX_CONSUMED)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item         (item),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: hw/rtl/ccsm_ctrl.sv
// ----------------------------------------------------------------------------
// ccsm_ctrl
// Controller: sequences loads, pattern memory reads and class evaluations.
// ----------------------------------------------------------------------------
module ccsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  ccsm_pkg::op_t     item_op,
	input  ccsm_pkg::status_t status,
	output logic              item_stall,
	output ccsm_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	// Items are taken only while no evaluation is in flight.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item_op)
						ccsm_pkg::OP_LOAD_MASK: begin
							cmd.load_mask = 1'b1;
						end
						ccsm_pkg::OP_LOAD_OPER: begin
							cmd.load_oper = 1'b1;
						end
						ccsm_pkg::OP_CHAR: begin
							if (!status.decided) begin
								cmd.start = 1'b1;
								state_d   = ST_EVAL;
							end
						end
						ccsm_pkg::OP_END: begin
							if (status.decided) begin
								cmd.clear = 1'b1;
							end else begin
								cmd.start = 1'b1;
								state_d   = ST_EVAL;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_EVAL: begin
				// A result waits here until the output register can take it.
				if (!status.emit || status.out_free) begin
					cmd.apply = 1'b1;
					state_d   = status.more ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.reread = 1'b1;
				state_d    = ST_EVAL;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/ccsm_datapath.sv
// ----------------------------------------------------------------------------
// ccsm_datapath
// Datapath: pattern memories, matching state, class evaluation and the
// output register.
// ----------------------------------------------------------------------------
module ccsm_datapath #(
	parameter int MAX_CLASSES  = ccsm_pkg::MAX_CLASSES_DEF,
	parameter int MAX_CONSUMED = ccsm_pkg::MAX_CONSUMED_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ccsm_pkg::cmd_t                    cmd,
	output ccsm_pkg::status_t                 status,
	input  ccsm_pkg::item_t                   item,
	input  logic                              cfg_we,
	input  logic [ccsm_pkg::PLEN_CFG_W-1:0]   cfg_data,
	output logic                              result_valid,
	input  logic                              result_stall,
	output ccsm_pkg::result_t                 result
);

	localparam int CLS_W   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int PLEN_W  = $clog2(MAX_CLASSES + 1);
	localparam int CNT_W   = $clog2(MAX_CONSUMED + 1);
	localparam int WS_W    = ccsm_pkg::WORD_SEL_W;
	localparam int ADDR_W  = CLS_W + WS_W;
	localparam int DEPTH   = MAX_CLASSES * ccsm_pkg::WORDS_PER_CLASS;
	localparam int CW      = ccsm_pkg::CONSUMED_W;
	localparam int WB      = ccsm_pkg::WORD_BITS;

	// Pattern memories.
	logic [WB-1:0]           mask_mem [DEPTH];
	ccsm_pkg::cls_op_t       oper_mem [MAX_CLASSES];
	logic [WB-1:0]           mask_rd_q;
	ccsm_pkg::cls_op_t       oper_rd_q;

	// Matching state.
	logic [PLEN_W-1:0]       plen_q;
	logic [CLS_W-1:0]        cur_q;
	logic                    seen_q;
	logic                    decided_q;
	logic [CNT_W-1:0]        count_q;
	logic [ccsm_pkg::CHAR_W-1:0] ch_q;
	logic                    end_mode_q;

	// Output register.
	logic                    res_valid_q;
	ccsm_pkg::result_t       res_q;

	// Evaluation signals.
	logic                    cls_in_range;
	logic [WS_W-1:0]         rd_word;
	logic                    hit;
	logic                    fail;
	logic                    adv;
	logic                    consume;
	logic                    fin;
	logic                    set_seen;
	logic                    clr_seen;
	logic [PLEN_W-1:0]       cur_ext;
	logic [PLEN_W-1:0]       cur_next;
	logic                    pat_end;
	logic [CNT_W-1:0]        count_next;
	logic                    end_ok;
	logic                    res_matched;
	logic [CNT_W-1:0]        res_count;
	logic [PLEN_W-1:0]       plen_cfg;

	assign cls_in_range = (32'(item.class_index) < MAX_CLASSES);
	assign rd_word      = cmd.start ? item.subject_char[ccsm_pkg::CHAR_W-1 -: WS_W]
	                                : ch_q[ccsm_pkg::CHAR_W-1 -: WS_W];

	// Mask memory: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load_mask && cls_in_range) begin
			mask_mem[{CLS_W'(item.class_index), item.mask_word_index}] <= item.mask_word;
		end
		if (cmd.start || cmd.reread) begin
			mask_rd_q <= mask_mem[ADDR_W'({cur_q, rd_word})];
		end
	end

	// Operator memory, read alongside the mask word.
	always_ff @(posedge clk) begin
		if (cmd.load_oper && cls_in_range) begin
			oper_mem[CLS_W'(item.class_index)] <= item.class_operator;
		end
		if (cmd.start || cmd.reread) begin
			oper_rd_q <= oper_mem[cur_q];
		end
	end

	// Subject character and item kind held for the evaluation.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ch_q       <= item.subject_char;
			end_mode_q <= (item.op == ccsm_pkg::OP_END);
		end
	end

	// One class step for the held character.
	always_comb begin
		hit      = mask_rd_q[ch_q[$clog2(WB)-1:0]];
		fail     = 1'b0;
		adv      = 1'b0;
		consume  = 1'b0;
		fin      = 1'b0;
		set_seen = 1'b0;
		clr_seen = 1'b0;
		case (oper_rd_q)
			ccsm_pkg::OPR_ONCE: begin
				if (hit) begin
					consume = 1'b1;
					adv     = 1'b1;
					fin     = 1'b1;
				end else begin
					fail = 1'b1;
				end
			end
			ccsm_pkg::OPR_STAR: begin
				if (hit) begin
					consume = 1'b1;
					fin     = 1'b1;
				end else begin
					adv = 1'b1;
				end
			end
			ccsm_pkg::OPR_PLUS: begin
				if (hit) begin
					set_seen = 1'b1;
					consume  = 1'b1;
					fin      = 1'b1;
				end else if (seen_q) begin
					clr_seen = 1'b1;
					adv      = 1'b1;
				end else begin
					fail = 1'b1;
				end
			end
			ccsm_pkg::OPR_OPT: begin
				consume = hit;
				fin     = hit;
				adv     = 1'b1;
			end
			default: begin
				fail = 1'b1;
			end
		endcase
	end

	// Class advance, pattern end and saturating count.
	assign cur_ext    = PLEN_W'(cur_q);
	assign cur_next   = adv ? (cur_ext + PLEN_W'(1)) : cur_ext;
	assign pat_end    = !fail && (cur_next >= plen_q);
	assign count_next = (consume && (count_q < CNT_W'(MAX_CONSUMED))) ?
	                    (count_q + CNT_W'(1)) : count_q;

	// End of subject: only the last class, when it repeats, accepts.
	assign end_ok = ((cur_ext + PLEN_W'(1)) == plen_q) &&
	                ((oper_rd_q == ccsm_pkg::OPR_STAR) || (oper_rd_q == ccsm_pkg::OPR_PLUS));

	assign res_matched = end_mode_q ? end_ok : pat_end;
	assign res_count   = end_mode_q ? count_q : count_next;

	// Status toward the controller.
	always_comb begin
		status.decided  = decided_q;
		status.emit     = end_mode_q || fail || pat_end;
		status.more     = !end_mode_q && !fail && !pat_end && !fin;
		status.out_free = !res_valid_q || !result_stall;
	end

	// Clamp of the written pattern length to one through the class count.
	always_comb begin
		if (cfg_data == '0) begin
			plen_cfg = PLEN_W'(1);
		end else if (32'(cfg_data) > MAX_CLASSES) begin
			plen_cfg = PLEN_W'(MAX_CLASSES);
		end else begin
			plen_cfg = PLEN_W'(cfg_data);
		end
	end

	// Matching state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q    <= PLEN_W'(1);
			cur_q     <= '0;
			seen_q    <= 1'b0;
			decided_q <= 1'b0;
			count_q   <= '0;
		end else if (cfg_we) begin
			plen_q    <= plen_cfg;
			cur_q     <= '0;
			seen_q    <= 1'b0;
			decided_q <= 1'b0;
			count_q   <= '0;
		end else if (cmd.clear || (cmd.apply && end_mode_q)) begin
			cur_q     <= '0;
			seen_q    <= 1'b0;
			decided_q <= 1'b0;
			count_q   <= '0;
		end else if (cmd.apply) begin
			if (fail) begin
				decided_q <= 1'b1;
			end else begin
				count_q <= count_next;
				if (set_seen) begin
					seen_q <= 1'b1;
				end else if (clr_seen) begin
					seen_q <= 1'b0;
				end
				if (pat_end) begin
					decided_q <= 1'b1;
				end else begin
					cur_q <= CLS_W'(cur_next);
				end
			end
		end
	end

	// Output register: a waiting result is dropped once the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.apply && status.emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && status.emit) begin
			res_q.matched  <= res_matched;
			res_q.consumed <= res_matched ? CW'(res_count) : '0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// File: hw/rtl/ccsm_checker.sv
// ----------------------------------------------------------------------------
// ccsm_checker
// Port-level checks of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
module ccsm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_stall,
	input ccsm_pkg::item_t                 item,
	input logic                            result_valid,
	input logic                            result_stall,
	input ccsm_pkg::result_t               result,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);

	// A stalled result stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result transaction dropped while stalled");

	// A stalled result keeps its payload.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	// A failed subject reports no consumed characters.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.matched |-> (result.consumed == '0))
		else $error("unmatched result with nonzero count");

	// A pattern load completes at once and leaves the input open.
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall &&
		((item.op == ccsm_pkg::OP_LOAD_MASK) || (item.op == ccsm_pkg::OP_LOAD_OPER))
		|=> !item_stall)
		else $error("input stalled after a load transaction");

	// A configuration write is taken in the cycle it is offered.
	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transaction not accepted");

endmodule

bind char_class_sequence_matcher_unit ccsm_checker u_ccsm_checker (.*);

// File: dv/char_class_sequence_matcher_unit_tb.sv
// ----------------------------------------------------------------------------
// char_class_sequence_matcher_unit_tb
// Self-checking testbench of the greedy character-class sequence matcher.
// Loads class masks and operators, streams subjects through the item channel
// under random idling on both sides, and compares every result transaction
// with a predictor kept inside the testbench. A short table of directed steps
// comes first, then an output hold-off and random pattern phases.
// ----------------------------------------------------------------------------
module char_class_sequence_matcher_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES    = 300;
	localparam int QUIET_CYCLES   = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 600;

	// How a directed step is checked.
	typedef enum {CHK_MODEL, CHK_NONE, CHK_RESULT} check_mode_t;

	typedef struct {
		bit                              is_cfg;
		logic [ccsm_pkg::PLEN_CFG_W-1:0] cfg_val;
		ccsm_pkg::item_t                 it;
		check_mode_t                     chk;
		ccsm_pkg::result_t               want;
	} step_row_t;

	logic                            clk;
	logic                            arst_n       = 1'b0;
	logic                            item_valid   = 1'b0;
	logic                            item_stall;
	ccsm_pkg::item_t                 item         = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	ccsm_pkg::result_t               result;
	logic                            cfg_valid    = 1'b0;
	logic                            cfg_ready;
	logic [ccsm_pkg::PLEN_CFG_W-1:0] cfg_data     = '0;

	// Predictor state: pattern memories, length and matching progress.
	logic [ccsm_pkg::WORD_BITS-1:0] pat_mask [0:4*ccsm_pkg::MAX_CLASSES_DEF-1];
	ccsm_pkg::cls_op_t              pat_oper [0:ccsm_pkg::MAX_CLASSES_DEF-1];
	int unsigned          pat_len;
	int unsigned          cur_cls;
	bit                   plus_seen;
	bit                   subj_done;
	int unsigned          consumed_cnt;

	ccsm_pkg::result_t pending_results [$];
	step_row_t         plan [$];

	int  mismatch_count  = 0;
	int  results_checked = 0;
	int  items_live      = 0;
	int  subjects_run    = 0;
	int  settings_used   = 0;
	int  holds_done      = 0;
	int  quiet_cycles    = 0;
	bit  send_calm       = 1'b1;
	bit  rx_calm         = 1'b0;
	bit  hold_req        = 1'b0;

	char_class_sequence_matcher_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Matching progress goes back to the start of a subject.
	function automatic void clear_subject();
		cur_cls      = 0;
		plus_seen    = 1'b0;
		subj_done    = 1'b0;
		consumed_cnt = 0;
	endfunction

	// A length write is clamped to 1..MAX_CLASSES and abandons the subject.
	function automatic void apply_length(input logic [ccsm_pkg::PLEN_CFG_W-1:0] v);
		if (v == 0)
			pat_len = 1;
		else if (v > ccsm_pkg::MAX_CLASSES_DEF)
			pat_len = ccsm_pkg::MAX_CLASSES_DEF;
		else
			pat_len = v;
		clear_subject();
	endfunction

	function automatic void count_char();
		if (consumed_cnt < ccsm_pkg::MAX_CONSUMED_DEF)
			consumed_cnt++;
	endfunction

	// Advances the predictor by one transaction; returns 1 when it yields a result.
	function automatic bit predict_match(input ccsm_pkg::item_t it,
			output ccsm_pkg::result_t res);
		bit hit;
		bit settled;
		res = '0;
		case (it.op)
			ccsm_pkg::OP_LOAD_MASK: begin
				pat_mask[{it.class_index, it.mask_word_index}] = it.mask_word;
				return 1'b0;
			end
			ccsm_pkg::OP_LOAD_OPER: begin
				pat_oper[it.class_index] = it.class_operator;
				return 1'b0;
			end
			ccsm_pkg::OP_END: begin
				settled = !subj_done;
				if (settled) begin
					res.matched = (cur_cls + 1 == pat_len) &&
						(pat_oper[cur_cls] == ccsm_pkg::OPR_STAR ||
						 pat_oper[cur_cls] == ccsm_pkg::OPR_PLUS);
					res.consumed = res.matched ?
						ccsm_pkg::CONSUMED_W'(consumed_cnt) : '0;
				end
				clear_subject();
				return settled;
			end
			default: begin
				if (subj_done)
					return 1'b0;
				// A class that misses may pass the same character on to the next one.
				while (1'b1) begin
					hit = pat_mask[{cur_cls[4:0], it.subject_char[7:6]}][it.subject_char[5:0]];
					settled = 1'b0;
					case (pat_oper[cur_cls])
						ccsm_pkg::OPR_ONCE: begin
							if (!hit) begin
								subj_done = 1'b1;
								return 1'b1;
							end
							count_char();
							cur_cls++;
							settled = 1'b1;
						end
						ccsm_pkg::OPR_STAR: begin
							if (hit) begin
								count_char();
								settled = 1'b1;
							end else
								cur_cls++;
						end
						ccsm_pkg::OPR_PLUS: begin
							if (hit) begin
								plus_seen = 1'b1;
								count_char();
								settled = 1'b1;
							end else if (plus_seen) begin
								plus_seen = 1'b0;
								cur_cls++;
							end else begin
								subj_done = 1'b1;
								return 1'b1;
							end
						end
						default: begin
							if (hit) begin
								count_char();
								settled = 1'b1;
							end
							cur_cls++;
						end
					endcase
					if (cur_cls >= pat_len) begin
						subj_done    = 1'b1;
						res.matched  = 1'b1;
						res.consumed = ccsm_pkg::CONSUMED_W'(consumed_cnt);
						return 1'b1;
					end
					if (settled)
						return 1'b0;
				end
			end
		endcase
		return 1'b0;
	endfunction

	// Fully random transaction, so that fields a step does not use still toggle.
	function automatic ccsm_pkg::item_t random_item();
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		return ccsm_pkg::item_t'(raw[$bits(ccsm_pkg::item_t)-1:0]);
	endfunction

	function automatic logic [ccsm_pkg::WORD_BITS-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return '0;
			2: return {$urandom() & $urandom() & $urandom(), $urandom() & $urandom() & $urandom()};
			3: return {$urandom() | $urandom(), $urandom() | $urandom()};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// Picks a character that the given class accepts, random if it has none.
	function automatic logic [ccsm_pkg::CHAR_W-1:0] pick_hit(input int c);
		int start;
		logic [ccsm_pkg::CHAR_W-1:0] code;
		start = $urandom_range(0, 255);
		for (int k = 0; k < ccsm_pkg::ALPHABET_SIZE; k++) begin
			code = ccsm_pkg::CHAR_W'(start + k);
			if (pat_mask[{c[4:0], code[7:6]}][code[5:0]])
				return code;
		end
		return ccsm_pkg::CHAR_W'($urandom());
	endfunction

	function automatic void add_row(input check_mode_t chk, input ccsm_pkg::op_t op,
			input int cls, input int widx, input logic [ccsm_pkg::WORD_BITS-1:0] word,
			input ccsm_pkg::cls_op_t oper, input logic [ccsm_pkg::CHAR_W-1:0] ch,
			input bit m, input int n);
		step_row_t r;
		r.is_cfg                = 1'b0;
		r.cfg_val               = '0;
		r.it.op                 = op;
		r.it.class_index        = ccsm_pkg::CLS_IDX_W'(cls);
		r.it.mask_word_index    = ccsm_pkg::WORD_SEL_W'(widx);
		r.it.mask_word          = word;
		r.it.class_operator     = oper;
		r.it.subject_char       = ch;
		r.chk                   = chk;
		r.want.matched          = m;
		r.want.consumed         = ccsm_pkg::CONSUMED_W'(n);
		plan.push_back(r);
	endfunction

	function automatic void add_cfg(input logic [ccsm_pkg::PLEN_CFG_W-1:0] v);
		step_row_t r;
		r.is_cfg  = 1'b1;
		r.cfg_val = v;
		r.it      = '0;
		r.chk     = CHK_NONE;
		r.want    = '0;
		plan.push_back(r);
	endfunction

	// Directed steps, starting from an all-zero pattern of exact classes.
	function automatic void build_plan();
		// Reset state: a single exact class with an empty mask.
		add_row(CHK_RESULT, ccsm_pkg::OP_CHAR, 0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h00, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_CHAR, 0, 0, '0, ccsm_pkg::OPR_ONCE, 8'hFF, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_END,  0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h00, 1'b0, 0);
		add_row(CHK_RESULT, ccsm_pkg::OP_END,  0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h00, 1'b0, 0);
		// One-or-more over the top quarter of the alphabet.
		add_row(CHK_NONE,   ccsm_pkg::OP_LOAD_MASK, 0, 3, '1, ccsm_pkg::OPR_ONCE,
			8'h00, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_LOAD_OPER, 0, 0, '0, ccsm_pkg::OPR_PLUS,
			8'h00, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_CHAR, 0, 0, '0, ccsm_pkg::OPR_ONCE, 8'hFF, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_CHAR, 0, 0, '0, ccsm_pkg::OPR_ONCE, 8'hC0, 1'b0, 0);
		add_row(CHK_RESULT, ccsm_pkg::OP_END,  0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h00, 1'b1, 2);
		// A trailing one-or-more that saw no hit still matches.
		add_row(CHK_RESULT, ccsm_pkg::OP_END,  0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h00, 1'b1, 0);
		// A length of zero is taken as one.
		add_cfg(6'd0);
		add_row(CHK_RESULT, ccsm_pkg::OP_CHAR, 0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h00, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_END,  0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h00, 1'b0, 0);
		// The pattern runs out on the first character.
		add_row(CHK_NONE,   ccsm_pkg::OP_LOAD_OPER, 0, 0, '0, ccsm_pkg::OPR_ONCE,
			8'h00, 1'b0, 0);
		add_row(CHK_RESULT, ccsm_pkg::OP_CHAR, 0, 0, '0, ccsm_pkg::OPR_ONCE, 8'hFF, 1'b1, 1);
		add_row(CHK_NONE,   ccsm_pkg::OP_CHAR, 0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h80, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_END,  0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h00, 1'b0, 0);
		// A length above the class count is clamped; last class, optional operator.
		add_cfg(6'd63);
		add_row(CHK_NONE,   ccsm_pkg::OP_LOAD_OPER, 31, 0, '0, ccsm_pkg::OPR_OPT,
			8'h00, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_LOAD_MASK, 31, 0, 64'h1, ccsm_pkg::OPR_ONCE,
			8'h00, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_LOAD_OPER, 0, 0, '0, ccsm_pkg::OPR_STAR,
			8'h00, 1'b0, 0);
		add_row(CHK_RESULT, ccsm_pkg::OP_CHAR, 0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h41, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_END,  0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h00, 1'b0, 0);
		// Zero-or-more then an optional class that misses.
		add_cfg(6'd2);
		add_row(CHK_NONE,   ccsm_pkg::OP_LOAD_OPER, 1, 0, '0, ccsm_pkg::OPR_OPT,
			8'h00, 1'b0, 0);
		add_row(CHK_MODEL,  ccsm_pkg::OP_CHAR, 0, 0, '0, ccsm_pkg::OPR_ONCE, 8'hFF, 1'b0, 0);
		add_row(CHK_MODEL,  ccsm_pkg::OP_CHAR, 0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h05, 1'b0, 0);
		add_row(CHK_NONE,   ccsm_pkg::OP_END,  0, 0, '0, ccsm_pkg::OPR_ONCE, 8'h00, 1'b0, 0);
	endfunction

	task automatic note_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Offers one transaction after a random gap and records what it should yield.
	task automatic drive_item(input ccsm_pkg::item_t it, input check_mode_t chk,
			input ccsm_pkg::result_t want);
		int gap;
		bit some;
		ccsm_pkg::result_t got;
		gap = send_calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		if (it.op != ccsm_pkg::OP_CHAR || !subj_done)
			items_live++;
		some = predict_match(it, got);
		if (chk == CHK_MODEL && some)
			pending_results.push_back(got);
		else if (chk == CHK_RESULT)
			pending_results.push_back(want);
		@(negedge clk);
	endtask

	// Waits until every expected result is in and the block has gone quiet.
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(input logic [ccsm_pkg::PLEN_CFG_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		apply_length(v);
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_class(input int c, input logic [ccsm_pkg::WORD_BITS-1:0] word,
			input ccsm_pkg::cls_op_t oper, input bit rand_words);
		ccsm_pkg::item_t it;
		for (int w = 0; w < ccsm_pkg::WORDS_PER_CLASS; w++) begin
			it                 = random_item();
			it.op              = ccsm_pkg::OP_LOAD_MASK;
			it.class_index     = ccsm_pkg::CLS_IDX_W'(c);
			it.mask_word_index = ccsm_pkg::WORD_SEL_W'(w);
			it.mask_word       = rand_words ? rand_word() : word;
			drive_item(it, CHK_MODEL, '0);
		end
		it                = random_item();
		it.op             = ccsm_pkg::OP_LOAD_OPER;
		it.class_index    = ccsm_pkg::CLS_IDX_W'(c);
		it.class_operator = oper;
		drive_item(it, CHK_MODEL, '0);
	endtask

	// One subject: mostly built to walk the pattern, sometimes cut short or plain noise.
	task automatic run_subject(input int eff);
		logic [ccsm_pkg::CHAR_W-1:0] chars [$];
		int reps;
		int cut;
		ccsm_pkg::item_t it;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(0, 6)) chars.push_back(ccsm_pkg::CHAR_W'($urandom()));
		end else begin
			for (int c = 0; c < eff; c++) begin
				case (pat_oper[c])
					ccsm_pkg::OPR_ONCE: reps = 1;
					ccsm_pkg::OPR_STAR: reps = $urandom_range(0, 3);
					ccsm_pkg::OPR_PLUS: reps = $urandom_range(1, 3);
					default:  reps = $urandom_range(0, 1);
				endcase
				repeat (reps)
					chars.push_back(($urandom_range(0, 11) == 0) ?
						ccsm_pkg::CHAR_W'($urandom()) : pick_hit(c));
			end
			if ($urandom_range(0, 2) == 0) begin
				cut = $urandom_range(0, 2);
				while (cut > 0 && chars.size() > 0) begin
					void'(chars.pop_back());
					cut--;
				end
			end
			repeat ($urandom_range(0, 2)) chars.push_back(ccsm_pkg::CHAR_W'($urandom()));
		end
		send_calm = ($urandom_range(0, 3) == 0);
		foreach (chars[k]) begin
			it              = random_item();
			it.op           = ccsm_pkg::OP_CHAR;
			it.subject_char = chars[k];
			drive_item(it, CHK_MODEL, '0);
		end
		it    = random_item();
		it.op = ccsm_pkg::OP_END;
		drive_item(it, CHK_MODEL, '0);
		subjects_run++;
	endtask

	// Result side: random stall before each transaction, or a long hold-off on request.
	initial begin
		int hold_left;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
				holds_done++;
			end else
				hold_left = rx_calm ? 0 : $urandom_range(0, 9);
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				repeat (hold_left) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	// Each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		ccsm_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (pending_results.size() == 0)
				note_mismatch($sformatf("unexpected result matched=%0d consumed=%0d",
					result.matched, result.consumed));
			else begin
				want = pending_results.pop_front();
				if (result.matched !== want.matched)
					note_mismatch($sformatf("matched is %b, expected %b",
						result.matched, want.matched));
				if (result.consumed !== want.consumed)
					note_mismatch($sformatf("consumed is %0d, expected %0d",
						result.consumed, want.consumed));
			end
		end
	end

	// Ends the run when no transaction moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Main sequence.
	initial begin
		ccsm_pkg::item_t it;
		int live_start;
		int phase;
		int eff;
		logic [ccsm_pkg::PLEN_CFG_W-1:0] len_val;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		pat_len = 1;
		clear_subject();

		// Clear the pattern memories so that no entry is read unwritten.
		send_calm = 1'b1;
		for (int c = 0; c < ccsm_pkg::MAX_CLASSES_DEF; c++)
			load_class(c, '0, ccsm_pkg::OPR_ONCE, 1'b0);

		// Directed table.
		build_plan();
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_length(plan[i].cfg_val);
			else begin
				send_calm = ($urandom_range(0, 2) == 0);
				drive_item(plan[i].it, plan[i].chk, plan[i].want);
			end
		end

		// Output hold-off while the sender keeps offering result-producing subjects.
		write_length(6'd1);
		send_calm = 1'b1;
		load_class(0, '1, ccsm_pkg::OPR_ONCE, 1'b0);
		hold_req  = 1'b1;
		send_calm = 1'b1;
		repeat (24) begin
			repeat ($urandom_range(1, 2)) begin
				it              = random_item();
				it.op           = ccsm_pkg::OP_CHAR;
				it.subject_char = ccsm_pkg::CHAR_W'($urandom());
				drive_item(it, CHK_MODEL, '0);
			end
			it    = random_item();
			it.op = ccsm_pkg::OP_END;
			drive_item(it, CHK_MODEL, '0);
		end

		// Random pattern phases.
		live_start = items_live;
		phase      = 0;
		while (items_live - live_start < RANDOM_ITEMS) begin
			case (phase)
				0: len_val = 6'd1;
				1: len_val = 6'd32;
				2: len_val = 6'd0;
				3: len_val = 6'd63;
				default: len_val = ($urandom_range(0, 7) == 0) ?
					ccsm_pkg::PLEN_CFG_W'($urandom_range(0, 63)) :
					ccsm_pkg::PLEN_CFG_W'($urandom_range(1, 6));
			endcase
			write_length(len_val);
			eff       = pat_len;
			rx_calm   = ($urandom_range(0, 3) == 0);
			send_calm = ($urandom_range(0, 3) == 0);
			for (int c = 0; c < eff; c++)
				if (eff <= 6 || $urandom_range(0, 3) == 0)
					load_class(c, '0, ccsm_pkg::cls_op_t'($urandom_range(0, 3)), 1'b1);
			repeat ((eff > 8) ? 2 : $urandom_range(3, 8)) begin
				if ($urandom_range(0, 9) == 0)
					drive_item(random_item(), CHK_MODEL, '0);
				run_subject(eff);
			end
			phase++;
		end

		settle();
		$display("Covered %0d live transactions, %0d results, %0d subjects, %0d length writes.",
			items_live, results_checked, subjects_run, settings_used);
		$display("Included %0d output hold-off(s) of %0d cycles and both length clamps.",
			holds_done, HOLD_CYCLES);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
